// ===== rtl/fault_code_status_table_defines.svh =====
// Assertion macros used by the fault code status table sequencer.
`ifndef FAULT_CODE_STATUS_TABLE_DEFINES_SVH
`define FAULT_CODE_STATUS_TABLE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FCST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define FCST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fcst_pkg.sv =====
// Types and constants of the fault code status table.
`timescale 1ns / 1ps
package fcst_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int USED_W = $clog2(TABLE_DEPTH + 1);
    localparam int CODE_W = 24;
    localparam int MCNT_W = 5;

    localparam logic [CODE_W-1:0] ALL_GROUPS = 24'hFFFFFF;
    localparam logic [MCNT_W-1:0] LIST_CAP = 5'd16;
    localparam logic [MCNT_W-1:0] COUNT_MAX = 5'd31;
    localparam logic [7:0] BIT_FAILED = 8'h01;
    localparam logic [7:0] BIT_CONFIRMED = 8'h08;
    localparam logic [7:0] BIT_NOT_COMPLETE = 8'h40;

    typedef enum logic [2:0] {
        ACT_REPORT      = 3'd0,
        ACT_CLEAR_ALL   = 3'd1,
        ACT_CLEAR_GROUP = 3'd2,
        ACT_COUNT       = 3'd3,
        ACT_LIST_MASK   = 3'd4,
        ACT_LIST_ALL    = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_END,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic [2:0]        action;
        logic [CODE_W-1:0] dtc_code;
        logic [7:0]        status_mask;
        logic [4:0]        max_entries;
    } t_req;

    typedef struct packed {
        logic              entry_valid;
        logic [CODE_W-1:0] code_out;
        logic [7:0]        status_out;
        logic [MCNT_W-1:0] match_count;
        logic              stored;
        logic              last;
    } t_res;

    typedef struct packed {
        logic              valid;
        logic [7:0]        status;
        logic [CODE_W-1:0] code;
    } t_slot;

    typedef struct packed {
        logic code_hit;
        logic mask_hit;
    } t_cmp;

    typedef struct packed {
        logic              wipe;
        logic              clr;
        logic              fill;
        logic              mark;
        logic              bump;
        logic [IDX_W-1:0]  idx;
        logic [CODE_W-1:0] code;
    } t_tbl_cmd;

endpackage

// ===== rtl/fcst_cmp.sv =====
// Shared compare unit that tests one table slot against the current request.
`timescale 1ns / 1ps
module fcst_cmp import fcst_pkg::*; (
    input  t_slot             i_slot,
    input  logic [CODE_W-1:0] i_code,
    input  logic [7:0]        i_mask,
    output t_cmp              o_cmp
);

    assign o_cmp.code_hit = i_slot.valid && (i_slot.code == i_code);
    assign o_cmp.mask_hit = i_slot.valid && ((i_slot.status & i_mask) != 8'h00);

endmodule

// ===== rtl/fcst_store.sv =====
// Slot storage of the fault code status table with its used-slot count.
`timescale 1ns / 1ps
module fcst_store import fcst_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_tbl_cmd          i_cmd,
    input  logic [IDX_W-1:0]  i_rd_idx,
    output t_slot             o_slot,
    output logic [USED_W-1:0] o_used
);

    logic [CODE_W-1:0]      r_code [TABLE_DEPTH];
    logic [7:0]             r_status [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [USED_W-1:0]      r_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.wipe) begin
            r_valid <= '0;
            r_used  <= '0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                r_status[i] <= 8'h00;
            end
        end else begin
            if (i_cmd.clr) begin
                r_valid[i_cmd.idx]  <= 1'b0;
                r_status[i_cmd.idx] <= 8'h00;
            end
            if (i_cmd.fill) begin
                r_valid[i_cmd.idx]  <= 1'b1;
                r_status[i_cmd.idx] <= (BIT_FAILED | BIT_CONFIRMED) & ~BIT_NOT_COMPLETE;
            end
            if (i_cmd.mark) begin
                r_status[i_cmd.idx] <= (r_status[i_cmd.idx] | BIT_FAILED | BIT_CONFIRMED)
                                       & ~BIT_NOT_COMPLETE;
            end
            if (i_cmd.bump) begin
                r_used <= r_used + USED_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill) begin
            r_code[i_cmd.idx] <= i_cmd.code;
        end
    end

    assign o_slot.valid  = r_valid[i_rd_idx];
    assign o_slot.status = r_status[i_rd_idx];
    assign o_slot.code   = r_code[i_rd_idx];
    assign o_used        = r_used;

endmodule

// ===== rtl/fcst_seq.sv =====
// Sequencer scanning a slot per cycle while no list stalls; builds results.
`timescale 1ns / 1ps
`include "fault_code_status_table_defines.svh"
module fcst_seq import fcst_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_req_valid,
    output logic              o_req_stall,
    input  t_req              i_req,
    output logic              o_res_valid,
    input  logic              i_res_stall,
    output t_res              o_res,
    input  t_slot             i_slot,
    input  t_cmp              i_cmp,
    input  logic [USED_W-1:0] i_used,
    output logic [IDX_W-1:0]  o_rd_idx,
    output t_tbl_cmd          o_cmd
);

    t_state            r_state, n_state;
    logic              r_rep_en;
    t_req              r_req, n_req;
    logic [USED_W-1:0] r_idx, n_idx;
    logic [MCNT_W-1:0] r_cnt, n_cnt;
    logic              r_found, n_found;
    logic [IDX_W-1:0]  r_hit_idx, n_hit_idx;
    logic              r_free_ok, n_free_ok;
    logic [IDX_W-1:0]  r_free_idx, n_free_idx;
    logic              r_held_ok, n_held_ok;
    t_res              r_held, n_held;
    t_res              r_res, n_res;
    logic              r_out_valid, n_out_valid;
    t_res              r_out, n_out;

    logic              out_free;
    logic              scan_end;
    logic              qual;
    logic [MCNT_W-1:0] cap;

    assign out_free = !r_out_valid || !i_res_stall;
    assign scan_end = (r_idx == i_used);
    assign cap = (r_req.max_entries > LIST_CAP) ? LIST_CAP : r_req.max_entries;
    assign qual = i_slot.valid && ((r_req.action == ACT_LIST_ALL) || i_cmp.mask_hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rep_en    <= 1'b1;
            r_out_valid <= 1'b0;
            r_held_ok   <= 1'b0;
            r_found     <= 1'b0;
            r_free_ok   <= 1'b0;
            r_idx       <= '0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_held_ok   <= n_held_ok;
            r_found     <= n_found;
            r_free_ok   <= n_free_ok;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            if (i_cfg_we) begin
                r_rep_en <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_hit_idx  <= n_hit_idx;
        r_free_idx <= n_free_idx;
        r_held     <= n_held;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_found     = r_found;
        n_hit_idx   = r_hit_idx;
        n_free_ok   = r_free_ok;
        n_free_idx  = r_free_idx;
        n_held_ok   = r_held_ok;
        n_held      = r_held;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_cmd       = '0;
        o_cmd.idx   = r_idx[IDX_W-1:0];
        o_cmd.code  = r_req.dtc_code;

        if (r_out_valid && !i_res_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_req      = i_req;
                    n_idx      = '0;
                    n_cnt      = '0;
                    n_found    = 1'b0;
                    n_free_ok  = 1'b0;
                    n_held_ok  = 1'b0;
                    n_res      = '0;
                    n_res.last = 1'b1;
                    if ((i_req.action == ACT_CLEAR_ALL) ||
                        ((i_req.action == ACT_CLEAR_GROUP) && (i_req.dtc_code == ALL_GROUPS)))
                    begin
                        o_cmd.wipe = 1'b1;
                        n_state    = ST_RESULT;
                    end else if ((i_req.action == ACT_REPORT) && !r_rep_en) begin
                        n_state = ST_RESULT;
                    end else if ((i_req.action == ACT_REPORT) ||
                                 (i_req.action == ACT_CLEAR_GROUP) ||
                                 (i_req.action == ACT_COUNT) ||
                                 (i_req.action == ACT_LIST_MASK) ||
                                 (i_req.action == ACT_LIST_ALL)) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_RESULT;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    n_state = ST_END;
                end else begin
                    unique case (r_req.action)
                        ACT_REPORT: begin
                            if (i_cmp.code_hit) begin
                                n_found   = 1'b1;
                                n_hit_idx = r_idx[IDX_W-1:0];
                                n_state   = ST_END;
                            end else begin
                                if (!i_slot.valid && !r_free_ok) begin
                                    n_free_ok  = 1'b1;
                                    n_free_idx = r_idx[IDX_W-1:0];
                                end
                                n_idx = r_idx + USED_W'(1);
                            end
                        end
                        ACT_CLEAR_GROUP: begin
                            o_cmd.clr = i_cmp.code_hit;
                            n_idx     = r_idx + USED_W'(1);
                        end
                        ACT_COUNT: begin
                            if (i_cmp.mask_hit && (r_cnt != COUNT_MAX)) begin
                                n_cnt = r_cnt + MCNT_W'(1);
                            end
                            n_idx = r_idx + USED_W'(1);
                        end
                        ACT_LIST_MASK, ACT_LIST_ALL: begin
                            if (!qual) begin
                                n_idx = r_idx + USED_W'(1);
                            end else if (r_cnt >= cap) begin
                                n_state = ST_END;
                            end else if (!r_held_ok || out_free) begin
                                if (r_held_ok) begin
                                    n_out_valid = 1'b1;
                                    n_out       = r_held;
                                end
                                n_held.entry_valid = 1'b1;
                                n_held.code_out    = i_slot.code;
                                n_held.status_out  = i_slot.status;
                                n_held.match_count = r_cnt + MCNT_W'(1);
                                n_held.stored      = 1'b0;
                                n_held.last        = 1'b0;
                                n_held_ok          = 1'b1;
                                n_cnt              = r_cnt + MCNT_W'(1);
                                n_idx              = r_idx + USED_W'(1);
                            end
                        end
                        default: begin
                            n_state = ST_END;
                        end
                    endcase
                end
            end
            ST_END: begin
                n_state = ST_RESULT;
                unique case (r_req.action)
                    ACT_REPORT: begin
                        if (r_found) begin
                            o_cmd.mark   = 1'b1;
                            o_cmd.idx    = r_hit_idx;
                            n_res.stored = 1'b1;
                        end else if (r_free_ok) begin
                            o_cmd.fill   = 1'b1;
                            o_cmd.idx    = r_free_idx;
                            n_res.stored = 1'b1;
                        end else if (i_used >= USED_W'(TABLE_DEPTH)) begin
                            n_res.stored = 1'b0;
                        end else begin
                            o_cmd.fill   = 1'b1;
                            o_cmd.bump   = 1'b1;
                            o_cmd.idx    = i_used[IDX_W-1:0];
                            n_res.stored = 1'b1;
                        end
                    end
                    ACT_COUNT: begin
                        n_res.match_count = r_cnt;
                    end
                    ACT_LIST_MASK, ACT_LIST_ALL: begin
                        if (r_held_ok) begin
                            n_res      = r_held;
                            n_res.last = 1'b1;
                            n_held_ok  = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_RESULT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_req_stall = (r_state != ST_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;
    assign o_rd_idx    = r_idx[IDX_W-1:0];

    `FCST_ASSERT_NOW(a_scan_in_range, i_clk, i_rst_n,
        (r_state == ST_SCAN), (r_idx <= i_used), "scan index passed the used count")
    `FCST_ASSERT_NOW(a_used_in_range, i_clk, i_rst_n,
        1'b1, (i_used <= USED_W'(TABLE_DEPTH)), "used count exceeds the table depth")
    `FCST_ASSERT_NOW(a_list_within_cap, i_clk, i_rst_n,
        r_held_ok, ((r_cnt != '0) && (r_cnt <= LIST_CAP)), "list count out of range")
    `FCST_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        (i_req_valid && !o_req_stall), o_req_stall, "block took two requests back to back")

endmodule

// ===== rtl/fault_code_status_table.sv =====
// Top level of the fault code status table.
`timescale 1ns / 1ps
// The table keeps TABLE_DEPTH slots of fault code, status byte and valid mark and
// serves one request at a time: report, clear all, clear group, count and list.
// One compare unit walks the slots in use, one slot per clock, for a report
// while reporting is on, a group clear, a count or a list; a clear all, or a
// group clear of ALL_GROUPS, wipes the table without a walk, and a list pauses
// its walk while a listed result waits to be taken. The request side stalls
// the whole time a request is worked on; a finished result sits in an output
// register, so the next request can be taken while it waits to be collected.
module fault_code_status_table import fcst_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    input  logic i_req_valid,
    output logic o_req_stall,
    input  t_req i_req,
    output logic o_res_valid,
    input  logic i_res_stall,
    output t_res o_res
);

    t_slot             slot;
    t_cmp              cmp;
    t_tbl_cmd          cmd;
    logic [USED_W-1:0] used;
    logic [IDX_W-1:0]  rd_idx;
    logic [CODE_W-1:0] u_seq_code;
    logic [7:0]        u_seq_mask;
    logic [7:0]        r_seq_mask;

    fcst_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_rd_idx (rd_idx),
        .o_slot   (slot),
        .o_used   (used)
    );

    fcst_cmp u_cmp (
        .i_slot (slot),
        .i_code (i_req_valid && !o_req_stall ? i_req.dtc_code : u_seq_code),
        .i_mask (u_seq_mask),
        .o_cmp  (cmp)
    );

    assign u_seq_code = cmd.code;
    assign u_seq_mask = r_seq_mask;

    always_ff @(posedge i_clk) begin
        if (i_req_valid && !o_req_stall) begin
            r_seq_mask <= i_req.status_mask;
        end
    end

    fcst_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .o_res       (o_res),
        .i_slot      (slot),
        .i_cmp       (cmp),
        .i_used      (used),
        .o_rd_idx    (rd_idx),
        .o_cmd       (cmd)
    );

endmodule

// ===== sim/fault_code_status_table_checker.sv =====
// Checker that predicts the fault code status table's results and compares them.
`timescale 1ns / 1ps
module fault_code_status_table_checker import fcst_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    input  logic i_req_valid,
    input  logic i_req_stall,
    input  t_req i_req,
    input  logic i_res_valid,
    input  logic i_res_stall,
    input  t_res i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);

    logic [CODE_W-1:0] dtc_code   [TABLE_DEPTH];
    logic [7:0]        dtc_status [TABLE_DEPTH];
    logic              dtc_valid  [TABLE_DEPTH];
    int                dtc_used;
    logic              reporting_on;

    t_res expected_results[$];
    int   fail_total;
    int   checked_total;

    initial begin
        fail_total = 0;
        checked_total = 0;
        o_fail_count = 0;
        o_pending = 0;
        o_checked = 0;
    end

    function automatic void wipe_dtc_table();
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            dtc_status[i] = '0;
            dtc_valid[i] = 1'b0;
        end
        dtc_used = 0;
    endfunction

    function automatic logic store_report(logic [CODE_W-1:0] code);
        int hit;
        int spare;
        hit = -1;
        spare = -1;
        if (!reporting_on) begin
            return 1'b0;
        end
        for (int i = 0; i < dtc_used && i < TABLE_DEPTH; i++) begin
            if (dtc_valid[i] && dtc_code[i] == code) begin
                hit = i;
                break;
            end
            if (!dtc_valid[i] && spare < 0) begin
                spare = i;
            end
        end
        if (hit < 0) begin
            if (spare < 0) begin
                if (dtc_used >= TABLE_DEPTH) begin
                    return 1'b0;
                end
                spare = dtc_used;
                dtc_used++;
            end
            hit = spare;
            dtc_code[hit] = code;
            dtc_status[hit] = '0;
            dtc_valid[hit] = 1'b1;
        end
        dtc_status[hit] = (dtc_status[hit] | BIT_FAILED | BIT_CONFIRMED) & ~BIT_NOT_COMPLETE;
        return 1'b1;
    endfunction

    function automatic t_res make_result(logic ev, logic [CODE_W-1:0] code, logic [7:0] st,
                                         logic [MCNT_W-1:0] cnt, logic stored, logic last);
        t_res r;
        r.entry_valid = ev;
        r.code_out = code;
        r.status_out = st;
        r.match_count = cnt;
        r.stored = stored;
        r.last = last;
        return r;
    endfunction

    function automatic void predict_request(t_req r);
        int   n;
        int   cap;
        logic held_any;
        t_res held;
        n = 0;
        held_any = 1'b0;
        held = '0;
        cap = (r.max_entries > LIST_CAP) ? int'(LIST_CAP) : int'(r.max_entries);
        if (r.action == ACT_REPORT) begin
            expected_results.push_back(make_result(1'b0, '0, '0, '0,
                                                   store_report(r.dtc_code), 1'b1));
        end else if (r.action == ACT_CLEAR_ALL ||
                     (r.action == ACT_CLEAR_GROUP && r.dtc_code == ALL_GROUPS)) begin
            wipe_dtc_table();
            expected_results.push_back(make_result(1'b0, '0, '0, '0, 1'b0, 1'b1));
        end else if (r.action == ACT_CLEAR_GROUP) begin
            for (int i = 0; i < dtc_used && i < TABLE_DEPTH; i++) begin
                if (dtc_valid[i] && dtc_code[i] == r.dtc_code) begin
                    dtc_valid[i] = 1'b0;
                    dtc_status[i] = '0;
                end
            end
            expected_results.push_back(make_result(1'b0, '0, '0, '0, 1'b0, 1'b1));
        end else if (r.action == ACT_COUNT) begin
            for (int i = 0; i < dtc_used && i < TABLE_DEPTH; i++) begin
                if (dtc_valid[i] && (dtc_status[i] & r.status_mask) != 8'h00) begin
                    n++;
                end
            end
            if (n > COUNT_MAX) begin
                n = COUNT_MAX;
            end
            expected_results.push_back(make_result(1'b0, '0, '0, MCNT_W'(n), 1'b0, 1'b1));
        end else if (r.action == ACT_LIST_MASK || r.action == ACT_LIST_ALL) begin
            for (int i = 0; i < dtc_used && i < TABLE_DEPTH && n < cap; i++) begin
                if (dtc_valid[i] &&
                    (r.action == ACT_LIST_ALL || (dtc_status[i] & r.status_mask) != 8'h00)) begin
                    if (held_any) begin
                        expected_results.push_back(held);
                    end
                    n++;
                    held = make_result(1'b1, dtc_code[i], dtc_status[i], MCNT_W'(n),
                                       1'b0, 1'b0);
                    held_any = 1'b1;
                end
            end
            if (held_any) begin
                held.last = 1'b1;
                expected_results.push_back(held);
            end else begin
                expected_results.push_back(make_result(1'b0, '0, '0, '0, 1'b0, 1'b1));
            end
        end else begin
            expected_results.push_back(make_result(1'b0, '0, '0, '0, 1'b0, 1'b1));
        end
    endfunction

    function automatic string describe(t_res r);
        return $sformatf("entry_valid=%0b code=%06h status=%02h count=%0d stored=%0b last=%0b",
                         r.entry_valid, r.code_out, r.status_out, r.match_count,
                         r.stored, r.last);
    endfunction

    function automatic void check_result(t_res got);
        t_res want;
        if (expected_results.size() == 0) begin
            fail_total++;
            if (fail_total <= 10) begin
                $display("%0t ERROR: result with no request outstanding: %s",
                         $realtime, describe(got));
            end
            return;
        end
        want = expected_results.pop_front();
        checked_total++;
        if (got.entry_valid !== want.entry_valid || got.code_out !== want.code_out ||
            got.status_out !== want.status_out || got.match_count !== want.match_count ||
            got.stored !== want.stored || got.last !== want.last) begin
            fail_total++;
            if (fail_total <= 10) begin
                $display("%0t ERROR: result mismatch", $realtime);
                $display("    expected %s", describe(want));
                $display("    actual   %s", describe(got));
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wipe_dtc_table();
            reporting_on = 1'b1;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                reporting_on = i_cfg_wdata;
            end
            if (i_res_valid && !i_res_stall) begin
                check_result(i_res);
            end
            if (i_req_valid && !i_req_stall) begin
                predict_request(i_req);
            end
        end
        o_fail_count <= fail_total;
        o_pending <= expected_results.size();
        o_checked <= checked_total;
    end

endmodule

// ===== sim/fault_code_status_table_tb.sv =====
// Testbench top of the fault code status table: request stimulus and the verdict.
`timescale 1ns / 1ps
module fault_code_status_table_tb;
    import fcst_pkg::*;

    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;
    localparam int POOL_SIZE = 20;
    localparam int SETTLE_CYCLES = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    t_req req = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    t_res res;

    int fail_count;
    int pending;
    int checked;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int n_reports = 0;
    int n_clears = 0;
    int n_counts = 0;
    int n_lists = 0;
    int n_unused = 0;

    logic [CODE_W-1:0] code_pool [POOL_SIZE];

    fault_code_status_table i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_req_valid(req_valid),
        .o_req_stall(req_stall),
        .i_req      (req),
        .o_res_valid(res_valid),
        .i_res_stall(res_stall),
        .o_res      (res)
    );

    fault_code_status_table_checker dtc_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req_valid (req_valid),
        .i_req_stall (req_stall),
        .i_req       (req),
        .i_res_valid (res_valid),
        .i_res_stall (res_stall),
        .i_res       (res),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        res_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic t_req make_request(logic [2:0] action, logic [CODE_W-1:0] code,
                                          logic [7:0] mask, logic [4:0] cap);
        t_req r;
        r.action = action;
        r.dtc_code = code;
        r.status_mask = mask;
        r.max_entries = cap;
        return r;
    endfunction

    function automatic t_req random_request();
        t_req r;
        int   pick;
        pick = $urandom_range(99);
        r.dtc_code = ($urandom_range(9) == 0) ? CODE_W'($urandom)
                                              : code_pool[$urandom_range(POOL_SIZE - 1)];
        case ($urandom_range(6))
            0: r.status_mask = BIT_FAILED;
            1: r.status_mask = BIT_CONFIRMED;
            2: r.status_mask = BIT_NOT_COMPLETE;
            3: r.status_mask = 8'hFF;
            4: r.status_mask = 8'h00;
            default: r.status_mask = 8'($urandom);
        endcase
        r.max_entries = ($urandom_range(3) == 0) ? 5'($urandom_range(31))
                                                 : 5'($urandom_range(LIST_CAP));
        if (pick < 45) begin
            r.action = ACT_REPORT;
        end else if (pick < 55) begin
            r.action = ACT_COUNT;
        end else if (pick < 67) begin
            r.action = ACT_LIST_MASK;
        end else if (pick < 79) begin
            r.action = ACT_LIST_ALL;
        end else if (pick < 91) begin
            r.action = ACT_CLEAR_GROUP;
        end else if (pick < 95) begin
            r.action = ACT_CLEAR_ALL;
        end else if (pick < 97) begin
            r.action = ACT_CLEAR_GROUP;
            r.dtc_code = ALL_GROUPS;
        end else begin
            r.action = ($urandom_range(1) == 0) ? ACT_SPARE_LO : ACT_SPARE_HI;
        end
        return r;
    endfunction

    task automatic send_request(input t_req r);
        req <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        case (r.action)
            ACT_REPORT: n_reports++;
            ACT_CLEAR_ALL, ACT_CLEAR_GROUP: n_clears++;
            ACT_COUNT: n_counts++;
            ACT_LIST_MASK, ACT_LIST_ALL: n_lists++;
            default: n_unused++;
        endcase
        if ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        end
    endtask

    task automatic wait_until_idle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reporting(input logic enable);
        wait_until_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= enable;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Fills the table from empty with distinct codes; the last report finds it full.
    task automatic fill_table_burst();
        send_request(make_request(ACT_CLEAR_ALL, '0, '0, '0));
        for (int k = 0; k <= TABLE_DEPTH; k++) begin
            send_request(make_request(ACT_REPORT, code_pool[k], 8'($urandom),
                                      5'($urandom)));
        end
    endtask

    task automatic run_random(input int count);
        for (int k = 0; k < count; k++) begin
            send_request(random_request());
        end
    endtask

    initial begin
        for (int k = 0; k < POOL_SIZE; k++) begin
            code_pool[k] = CODE_W'({$urandom, 5'(k)});
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_reporting(1'b1);

        send_request(make_request(ACT_LIST_ALL, 24'h000000, 8'hFF, 5'd16));
        send_request(make_request(ACT_COUNT, 24'h000000, 8'hFF, 5'd0));
        send_request(make_request(ACT_REPORT, 24'h000001, 8'h00, 5'd0));
        send_request(make_request(ACT_REPORT, 24'hFFFFFF, 8'h00, 5'd0));
        send_request(make_request(ACT_REPORT, 24'h000001, 8'hFF, 5'd31));
        send_request(make_request(ACT_REPORT, 24'h000000, 8'h00, 5'd0));
        send_request(make_request(ACT_COUNT, 24'h000000, BIT_FAILED | BIT_CONFIRMED, 5'd0));
        send_request(make_request(ACT_COUNT, 24'h000000, BIT_NOT_COMPLETE, 5'd0));
        send_request(make_request(ACT_COUNT, 24'hFFFFFF, 8'h00, 5'd31));
        send_request(make_request(ACT_LIST_MASK, 24'h000000, BIT_FAILED, 5'd31));
        send_request(make_request(ACT_LIST_MASK, 24'h000000, BIT_NOT_COMPLETE, 5'd16));
        send_request(make_request(ACT_LIST_ALL, 24'h000000, 8'h00, 5'd0));
        send_request(make_request(ACT_LIST_ALL, 24'h000000, 8'h00, 5'd1));
        send_request(make_request(ACT_CLEAR_GROUP, 24'h000001, 8'h00, 5'd0));
        send_request(make_request(ACT_CLEAR_GROUP, 24'h123456, 8'h00, 5'd0));
        send_request(make_request(ACT_REPORT, 24'hABCDEF, 8'h00, 5'd0));
        send_request(make_request(ACT_LIST_ALL, 24'h000000, 8'h00, 5'd31));
        send_request(make_request(ACT_SPARE_LO, 24'h000001, 8'h01, 5'd1));
        send_request(make_request(ACT_SPARE_HI, 24'hFFFFFF, 8'hFF, 5'd31));
        send_request(make_request(ACT_CLEAR_GROUP, ALL_GROUPS, 8'h00, 5'd0));
        send_request(make_request(ACT_REPORT, 24'h5A5A5A, 8'h00, 5'd0));
        send_request(make_request(ACT_CLEAR_ALL, 24'h000000, 8'h00, 5'd0));
        send_request(make_request(ACT_LIST_ALL, 24'h000000, 8'hFF, 5'd16));
        write_reporting(1'b0);
        send_request(make_request(ACT_REPORT, 24'h000001, 8'h00, 5'd0));
        send_request(make_request(ACT_LIST_ALL, 24'h000000, 8'hFF, 5'd16));
        write_reporting(1'b1);

        send_idle_pct = 11;
        recv_stall_pct = 82;
        fill_table_burst();
        run_random(85);

        write_reporting(1'b0);
        send_idle_pct = 82;
        recv_stall_pct = 11;
        run_random(30);
        write_reporting(1'b1);
        fill_table_burst();
        run_random(60);

        wait_until_idle();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fill_table_burst();
        run_random(85);

        wait_until_idle();
        $display("Covered %0d requests: %0d reports, %0d clears, %0d counts, %0d lists, %0d unused.",
                 n_reports + n_clears + n_counts + n_lists + n_unused,
                 n_reports, n_clears, n_counts, n_lists, n_unused);
        $display("Checked %0d results under three stall patterns and both reporting settings.",
                 checked);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/fcst_pkg.sv
rtl/fcst_cmp.sv
rtl/fcst_store.sv
rtl/fcst_seq.sv
rtl/fault_code_status_table.sv
sim/fault_code_status_table_checker.sv
sim/fault_code_status_table_tb.sv
